// ===== rtl/nsrd_pkg.sv =====
// shared types and constants for the nibble sprite rom decoder
`default_nettype none

package nsrd_pkg;

  localparam int WORD_W = 16;
  localparam int CFG_W  = 10;
  localparam int PIX_W  = 9;
  localparam int NIB_W  = 4;
  localparam int CNT_W  = 3;   // pixel count per word, 0..4

  localparam logic [NIB_W-1:0] NIB_EMPTY = 4'hf;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] rom_word;
    logic              new_sprite;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
    logic [NIB_W-1:0] pixel_value;
    logic             last;
  } out_t;

  // one word's worth of pixel writes, handed from front to back
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [PIX_W-1:0]  col;
    logic [PIX_W-1:0]  row;
    logic [CNT_W-1:0]  count;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/nsrd_front.sv =====
// front end: takes rom words, tracks column/row/skip state, issues pixel commands
`default_nettype none

module nsrd_front #(
  parameter int MAX_DIM = 512
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [nsrd_pkg::CFG_W-1:0]  cfg_width_i,
  input  wire logic [nsrd_pkg::CFG_W-1:0]  cfg_height_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire nsrd_pkg::in_t               in_data_i,
  output logic                             push_o,
  output nsrd_pkg::cmd_t                   cmd_o,
  input  wire logic                        full_i
);
  import nsrd_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = (DW > CFG_W) ? DW : CFG_W;

  logic [DW-1:0] column_q, column_d;
  logic [DW-1:0] row_q, row_d;
  logic          start_q, start_d;

  logic [DW-1:0] width, height;
  logic [CW-1:0] w_ext, h_ext;
  logic [DW-1:0] col_eff, row_eff, remaining, col_new;
  logic          start_eff, low_empty, finish, accept;
  logic [CNT_W-1:0] lim, count;

  assign w_ext  = CW'(cfg_width_i);
  assign h_ext  = CW'(cfg_height_i);
  assign width  = (w_ext > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(w_ext);
  assign height = (h_ext > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(h_ext);

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    col_eff   = in_data_i.new_sprite ? '0   : column_q;
    row_eff   = in_data_i.new_sprite ? '0   : row_q;
    start_eff = in_data_i.new_sprite ? 1'b1 : start_q;
    low_empty = (in_data_i.rom_word[NIB_W-1:0] == NIB_EMPTY);
    remaining = (col_eff < width) ? (width - col_eff) : '0;
    lim       = low_empty ? CNT_W'(3) : CNT_W'(4);
    count     = (remaining < DW'(lim)) ? CNT_W'(remaining) : lim;
    finish    = low_empty && (remaining >= DW'(4));
    col_new   = col_eff + DW'(count);

    column_d = col_eff;
    row_d    = row_eff;
    start_d  = start_eff;
    push_o   = 1'b0;

    if (row_eff >= height) begin
      // sprite done, word dropped
    end else if (start_eff && low_empty) begin
      // leading skip word
    end else if (start_eff && (width == '0)) begin
      row_d = height;
    end else begin
      push_o = accept && (count != '0);
      if (finish || (col_new >= width)) begin
        row_d    = row_eff + DW'(1);
        column_d = '0;
        start_d  = 1'b1;
      end else begin
        column_d = col_new;
        start_d  = 1'b0;
      end
    end

    cmd_o.word  = in_data_i.rom_word;
    cmd_o.col   = PIX_W'(col_eff);
    cmd_o.row   = PIX_W'(row_eff);
    cmd_o.count = count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
      start_q  <= 1'b1;
    end else if (accept) begin
      column_q <= column_d;
      row_q    <= row_d;
      start_q  <= start_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nsrd_queue.sv =====
// four-entry command fifo between front and back
`default_nettype none

module nsrd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire nsrd_pkg::cmd_t  cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output nsrd_pkg::cmd_t       cmd_o,
  output logic                 empty_o
);
  import nsrd_pkg::*;

  cmd_t       mem_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] fill_q;
  logic       do_push, do_pop;

  assign full_o  = (fill_q == 3'd4);
  assign empty_o = (fill_q == 3'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 2'd1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 2'd1;
      fill_q <= fill_q + 3'(do_push) - 3'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nsrd_back.sv =====
// back end: expands each command into pixel writes, one per cycle unless stalled, into the output register
`default_nettype none

module nsrd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire nsrd_pkg::cmd_t  cmd_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output nsrd_pkg::out_t       out_data_o
);
  import nsrd_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_q, out_d;
  logic       load, is_last;
  logic [NIB_W-1:0] nib;

  assign load    = !empty_i && (!out_valid_q || !out_stall_i);
  assign is_last = ({1'b0, idx_q} == (cmd_i.count - CNT_W'(1)));
  assign pop_o   = load && is_last;

  always_comb begin
    case (idx_q)
      2'd0:    nib = cmd_i.word[15:12];
      2'd1:    nib = cmd_i.word[11:8];
      2'd2:    nib = cmd_i.word[7:4];
      default: nib = cmd_i.word[3:0];
    endcase
    out_d.pixel_col   = cmd_i.col + PIX_W'(idx_q);
    out_d.pixel_row   = cmd_i.row;
    out_d.pixel_value = (nib == NIB_EMPTY) ? '0 : nib;
    out_d.last        = is_last;
    idx_d             = load ? (is_last ? 2'd0 : idx_q + 2'd1) : idx_q;
    out_valid_d       = load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/nibble_sprite_rom_decoder_unit.sv =====
// top level of the nibble sprite rom decoder
// usage:
//   input channel (in_valid_i / in_stall_o / in_data_i) takes one 16-bit rom word per
//   transaction; new_sprite restarts column, row and leading-skip mode for that word.
//   output channel (out_valid_o / out_stall_i / out_data_o) gives one pixel write per
//   transaction, last marks the final pixel of a word. words that write nothing give
//   no transaction at all.
//   config channel (cfg_valid_i / cfg_ready_o) writes sprite_width (index 0) and
//   sprite_height (index 1); always ready, write only while idle.
// timing:
//   front end takes a word per cycle while its 4-entry command queue has room;
//   back end emits one pixel per cycle while out_stall_i is low, so each queued word
//   gives 1 to 4 pixel writes through the single output register. a word's first
//   pixel passes through the command queue and then the output register.
// reset clears the state to row 0, column 0, skip mode, both registers to 0, and
// empties the queue. a stalled receiver holds the output register; the queue then
// fills and in_stall_o rises.
`default_nettype none

module nibble_sprite_rom_decoder_unit #(
  parameter int MAX_DIM = 512
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire nsrd_pkg::in_t               in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output nsrd_pkg::out_t                   out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic                        cfg_index_i,
  input  wire logic [nsrd_pkg::CFG_W-1:0]  cfg_data_i
);
  import nsrd_pkg::*;

  logic [CFG_W-1:0] width_q, height_q;
  logic             push, pop, full, empty;
  cmd_t             cmd_in, cmd_out;

  // configuration registers, no back-pressure
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // front: state tracking and word classification
  nsrd_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .cmd_o        (cmd_in),
    .full_i       (full)
  );

  // decoupling queue
  nsrd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .empty_o (empty)
  );

  // back: pixel expansion and output register
  nsrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/nsrd_checker.sv =====
// port-level checks for the decoder top level, with bind
`default_nettype none

module nsrd_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            out_valid_i,
  input wire logic            out_stall_i,
  input wire nsrd_pkg::out_t  out_data_i,
  input wire logic            cfg_ready_i
);
  import nsrd_pkg::*;

  // a stalled transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("output changed while stalled");

  // empty nibble never comes out as 15
  a_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.pixel_value != NIB_EMPTY))
    else $error("pixel value 15 emitted");

  // pixels of one word follow back to back on consecutive columns of one row
  a_word_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_stall_i && !out_data_i.last) |=>
      (out_valid_i
       && (out_data_i.pixel_col == PIX_W'($past(out_data_i.pixel_col) + PIX_W'(1)))
       && (out_data_i.pixel_row == $past(out_data_i.pixel_row))))
    else $error("broken pixel run within a word");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("config port not ready");

endmodule

bind nibble_sprite_rom_decoder_unit nsrd_checker u_nsrd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o),
  .cfg_ready_i (cfg_ready_o)
);

`default_nettype wire

// ===== tb/sv/nsrd_pixel_checker.sv =====
// pixel checker: predicts pixel writes from accepted rom words and compares them
`timescale 1ns / 100ps

module nsrd_pixel_checker #(
  parameter int MAX_DIM = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        word_valid_i,
  input  logic                        word_stall_i,
  input  nsrd_pkg::in_t               word_i,
  input  logic                        pix_valid_i,
  input  logic                        pix_stall_i,
  input  nsrd_pkg::out_t              pix_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic                        cfg_index_i,
  input  logic [nsrd_pkg::CFG_W-1:0]  cfg_data_i,
  output int                          mismatches_o,
  output int                          pending_o,
  output int                          words_seen_o,
  output int                          pixels_seen_o
);
  import nsrd_pkg::*;

  logic [CFG_W-1:0] sprite_w;
  logic [CFG_W-1:0] sprite_h;
  logic [CFG_W-1:0] cur_col;
  logic [CFG_W-1:0] cur_row;
  logic             skipping;
  out_t             pixels_due[$];

  // expected pixel writes for one rom word, state advanced as the block does
  task automatic decode_word(input in_t item);
    int   lim_w;
    int   lim_h;
    int   n;
    bit   early_end;
    logic [NIB_W-1:0] nib;
    out_t px_buf[4];
    lim_w = (sprite_w > MAX_DIM) ? MAX_DIM : int'(sprite_w);
    lim_h = (sprite_h > MAX_DIM) ? MAX_DIM : int'(sprite_h);
    n = 0;
    early_end = 1'b0;
    if (item.new_sprite) begin
      cur_col  = '0;
      cur_row  = '0;
      skipping = 1'b1;
    end
    if (cur_row >= lim_h) return;
    if (skipping) begin
      if (item.rom_word[NIB_W-1:0] == NIB_EMPTY) return;
      // zero width finishes every remaining row at once
      if (lim_w == 0) begin
        cur_row = lim_h[CFG_W-1:0];
        return;
      end
      skipping = 1'b0;
    end
    for (int i = 0; i < 4; i++) begin
      if (cur_col >= lim_w) break;
      nib = NIB_W'(item.rom_word >> (12 - 4 * i));
      if (i == 3 && nib == NIB_EMPTY) begin
        early_end = 1'b1;
        break;
      end
      px_buf[n].pixel_col   = cur_col[PIX_W-1:0];
      px_buf[n].pixel_row   = cur_row[PIX_W-1:0];
      px_buf[n].pixel_value = (nib == NIB_EMPTY) ? '0 : nib;
      px_buf[n].last        = 1'b0;
      cur_col = cur_col + 1'b1;
      n++;
    end
    if (n > 0) px_buf[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pixels_due.push_back(px_buf[i]);
    if (early_end || cur_col >= lim_w) begin
      cur_row  = cur_row + 1'b1;
      cur_col  = '0;
      skipping = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      sprite_w      = '0;
      sprite_h      = '0;
      cur_col       = '0;
      cur_row       = '0;
      skipping      = 1'b1;
      pixels_due.delete();
      mismatches_o  = 0;
      pending_o     = 0;
      words_seen_o  = 0;
      pixels_seen_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_WIDTH) sprite_w = cfg_data_i;
        else if (cfg_index_i == REG_HEIGHT) sprite_h = cfg_data_i;
      end
      if (word_valid_i && !word_stall_i) begin
        decode_word(word_i);
        words_seen_o++;
      end
      if (pix_valid_i && !pix_stall_i) begin
        pixels_seen_o++;
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel write col %0d row %0d value %0d",
                 pix_i.pixel_col, pix_i.pixel_row, pix_i.pixel_value);
          mismatches_o++;
        end else begin
          want = pixels_due.pop_front();
          if (pix_i.pixel_col !== want.pixel_col) begin
            $error("pixel_col: expected %0d, actual %0d", want.pixel_col, pix_i.pixel_col);
            mismatches_o++;
          end
          if (pix_i.pixel_row !== want.pixel_row) begin
            $error("pixel_row: expected %0d, actual %0d", want.pixel_row, pix_i.pixel_row);
            mismatches_o++;
          end
          if (pix_i.pixel_value !== want.pixel_value) begin
            $error("pixel_value: expected %0d, actual %0d",
                   want.pixel_value, pix_i.pixel_value);
            mismatches_o++;
          end
          if (pix_i.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, pix_i.last);
            mismatches_o++;
          end
        end
      end
      pending_o = pixels_due.size();
    end
  end

endmodule

// ===== tb/sv/nibble_sprite_rom_decoder_unit_tb.sv =====
// testbench top: drives rom words and geometry writes, stalls the pixel side, gives the verdict
`timescale 1ns / 100ps

module nibble_sprite_rom_decoder_unit_tb;
  import nsrd_pkg::*;

  localparam int SPRITE_MAX  = 512;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 7;
  localparam int PHASE_WORDS = 27;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             word_valid = 1'b0;
  logic             word_stall;
  in_t              word_data = '0;
  logic             pix_valid;
  logic             pix_stall = 1'b0;
  out_t             pix_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  int mismatches;
  int pending;
  int words_seen;
  int pixels_seen;

  int          cycle_count = 0;
  int          settings_done = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  nibble_sprite_rom_decoder_unit #(
    .MAX_DIM(SPRITE_MAX)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (word_valid),
    .in_stall_o (word_stall),
    .in_data_i  (word_data),
    .out_valid_o(pix_valid),
    .out_stall_i(pix_stall),
    .out_data_o (pix_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  nsrd_pixel_checker #(
    .MAX_DIM(SPRITE_MAX)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .word_valid_i (word_valid),
    .word_stall_i (word_stall),
    .word_i       (word_data),
    .pix_valid_i  (pix_valid),
    .pix_stall_i  (pix_stall),
    .pix_i        (pix_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .words_seen_o (words_seen),
    .pixels_seen_o(pixels_seen)
  );

  // pixel side backpressure: the mode is redrawn when its random run counter expires, so runs
  // of free flow, light noise, a fixed pattern and heavy stalling all show up
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     pix_stall <= 1'b0;
      STALL_LIGHT:    pix_stall <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: pix_stall <= ((stall_left % 5) < 2);
      default:        pix_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // drop valid for a number of cycles; nothing happens for zero so valid is
  // never lowered and raised in the same step
  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      word_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // one rom word transaction; valid stays high afterwards so bursts run back to back
  task automatic send_word(input logic [WORD_W-1:0] w, input logic restart);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) hold_off($urandom_range(0, 6));
    end
    burst_left--;
    word_data  <= in_t'{rom_word: w, new_sprite: restart};
    word_valid <= 1'b1;
    @(posedge clk);
    while (word_stall) @(posedge clk);
  endtask

  // wait until every predicted pixel has come out, then give words that write
  // nothing time to settle in the front end
  task automatic wait_drained();
    word_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // writes width then height in back-to-back config transactions
  task automatic set_geometry(input int w, input int h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= w[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  // random sprites: mostly a restart followed by a run of words sized to the
  // geometry, with stray restarts and dropped restarts mixed in as noise
  task automatic random_sprites(input int count, input int w, input int h);
    int               words_left;
    int               area;
    logic [WORD_W-1:0] word;
    logic             restart;
    words_left = 0;
    for (int k = 0; k < count; k++) begin
      restart = 1'b0;
      if (words_left == 0) begin
        area = ((w > SPRITE_MAX) ? SPRITE_MAX : w) * ((h > SPRITE_MAX) ? SPRITE_MAX : h);
        area = (area / 3 > 40) ? 40 : area / 3;
        words_left = $urandom_range(2, 4 + area);
        // first word of a phase may carry over the old position
        restart = (k > 0) ? 1'b1 : 1'($urandom_range(0, 1));
      end
      words_left--;
      word = WORD_W'($urandom);
      case ($urandom_range(0, 9))
        0, 1:    word[NIB_W-1:0] = NIB_EMPTY;
        2:       word = {4{NIB_EMPTY}};
        3:       word[WORD_W-1 -: NIB_W] = NIB_EMPTY;
        default: ;
      endcase
      if ($urandom_range(0, 19) == 0) restart = ~restart;
      // sender holds off until the pixel side is empty now and then
      if ($urandom_range(0, 39) == 0) wait_drained();
      send_word(word, restart);
    end
  endtask

  initial begin
    int w;
    int h;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full words, early end, leading skips, finished sprite, width cut-off
    gaps_on = 1'b0;
    set_geometry(10, 2);
    send_word(16'h0000, 1'b1);
    send_word(16'h12EF, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h123F, 1'b0);
    send_word(16'hFFF0, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hABCD, 1'b0);
    send_word(16'hFEDC, 1'b1);
    send_word(16'h89AB, 1'b0);
    send_word(16'hCDE1, 1'b0);
    send_word(16'h000F, 1'b0);
    send_word(16'hF00E, 1'b0);
    wait_drained();

    // zero width: first kept word closes out the sprite
    gaps_on = 1'b1;
    set_geometry(0, 3);
    send_word(16'h111F, 1'b1);
    send_word(16'h1110, 1'b0);
    send_word(16'h2222, 1'b0);
    wait_drained();

    // zero height writes nothing
    set_geometry(4, 0);
    send_word(16'h1234, 1'b1);
    send_word(16'hFFF0, 1'b0);
    wait_drained();

    // width lowered below the current column in the middle of a row
    set_geometry(8, 4);
    send_word(16'h1234, 1'b1);
    wait_drained();
    set_geometry(2, 4);
    send_word(16'h5678, 1'b0);
    send_word(16'h9ABC, 1'b0);
    wait_drained();

    // oversized registers saturate
    set_geometry(1023, 1023);
    send_word(16'h0123, 1'b1);
    send_word(16'hFEDC, 1'b0);
    wait_drained();

    // single pixel sprite
    set_geometry(1, 1);
    send_word(16'h7654, 1'b1);
    send_word(16'h3210, 1'b0);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin w = $urandom_range(1, 16);  h = $urandom_range(1, 4); end
        1: begin w = 1;                      h = $urandom_range(1, 6); end
        2: begin w = 1023;                   h = 1023;                 end
        3: begin w = $urandom_range(0, 3);   h = $urandom_range(0, 3); end
        4: begin w = 513;                    h = $urandom_range(1, 3); end
        5: begin w = $urandom_range(2, 40);  h = $urandom_range(1, 8); end
        default: begin w = $urandom_range(1, 12); h = 512;             end
      endcase
      // every third phase runs with no sender gaps at all
      gaps_on = (p % 3) != 0;
      set_geometry(w, h);
      random_sprites(PHASE_WORDS, w, h);
      wait_drained();
    end

    $display("covered %0d rom words and %0d pixel writes across %0d geometry settings",
             words_seen, pixels_seen, settings_done);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
